/* design/trlv_pkg.sv */
// Shared constants and types for the tuple run-length validator.
// Used by the top level and the result queue.
`default_nettype none

package trlv_pkg;

  localparam int LABEL_BITS      = 16;
  localparam int ALLOWED_ENTRIES = 6;
  localparam int FIFO_DEPTH      = 4;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 24;

  // Register indexes of the configuration port.
  localparam logic [CFG_INDEX_W-1:0] CFG_ALLOWED_COUNT = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_ENTRY_FIRST   = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_ENTRY_LAST    = 3'd6;

  localparam logic [15:0] HOST_MASK = 16'((32'd1 << LABEL_BITS) - 32'd1);
  localparam logic [7:0]  COUNT_MAX = 8'hFF;

  typedef struct packed {
    logic [15:0] host_label;
    logic [7:0]  run_order;
    logic [7:0]  run_total;
    logic        tuple_end;
    logic        tuple_error;
  } result_t;

  typedef struct packed {
    logic not_empty;
    logic room_two;
  } fifo_status_t;

endpackage

`default_nettype wire

/* design/trlv_result_fifo.sv */
// Four-entry result queue that takes up to two items per cycle and gives one.
// Depends on trlv_pkg for the result type and the depth.
`default_nettype none

module trlv_result_fifo (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic [1:0]            push_count,
  input  wire trlv_pkg::result_t     push_data0,
  input  wire trlv_pkg::result_t     push_data1,
  input  wire logic                  pop,
  output trlv_pkg::result_t          head,
  output trlv_pkg::fifo_status_t     status
);
  import trlv_pkg::*;

  localparam int PTR_W = $clog2(FIFO_DEPTH);
  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

  result_t            mem [FIFO_DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;

  always_ff @(posedge clk) begin
    if (push_count != 2'd0) mem[wr_ptr] <= push_data0;
    if (push_count == 2'd2) mem[wr_ptr + PTR_W'(1)] <= push_data1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PTR_W'(push_count);
      if (pop) rd_ptr <= rd_ptr + PTR_W'(1);
      count <= count + CNT_W'(push_count) - CNT_W'(pop);
    end
  end

  assign head             = mem[rd_ptr];
  assign status.not_empty = (count != '0);
  // Input is held off unless a whole item's worth of results still fits.
  assign status.room_two  = (count <= CNT_W'(FIFO_DEPTH - 2));

endmodule

`default_nettype wire

/* design/tuple_run_length_validator_unit.sv */
// Tuple run-length validator: groups equal tagged labels into runs, checks each run's
// label against an allowed table and its length against that entry's maximum order.
// Depends on trlv_pkg and trlv_result_fifo.
//
// One input item is taken every cycle with s_tready high. Each item is resolved in the
// cycle it is accepted and yields zero, one or two result items, queued in a four-entry
// result queue; the output drains one item per cycle with m_tready high. s_tready is low
// only while the queue has fewer than two free entries, so with m_tready high the block
// sustains one input item per cycle. Configuration writes are taken every cycle.
`default_nettype none

module tuple_run_length_validator_unit (
  input  wire logic                              clk,
  input  wire logic                              rst,
  // s_tdata: tagged_label[31:0]
  input  wire logic [31:0]                       s_tdata,
  input  wire logic                              s_tlast,
  input  wire logic                              s_tvalid,
  output logic                                   s_tready,
  // m_tdata: host_label[15:0], run_order[23:16], run_total[31:24]
  output logic [31:0]                            m_tdata,
  // m_tuser: tuple_error[0]
  output logic                                   m_tuser,
  output logic                                   m_tlast,
  output logic                                   m_tvalid,
  input  wire logic                              m_tready,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [trlv_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  wire logic [trlv_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import trlv_pkg::*;

  logic [2:0]            allowed_count;
  logic [23:0]           allowed_entry [ALLOWED_ENTRIES];

  logic [31:0]           run_value,      run_value_next;
  logic [7:0]            run_length,     run_length_next;
  logic [15:0]           run_host_label, run_host_label_next;
  logic [7:0]            run_max_order,  run_max_order_next;
  logic                  run_open,       run_open_next;
  logic                  error_seen,     error_seen_next;
  logic [7:0]            runs_emitted,   runs_emitted_next;

  logic [15:0]           host;
  logic [2:0]            table_size;
  logic                  lookup_hit;
  logic [7:0]            lookup_max;

  result_t               res0, res1;
  logic [1:0]            nres;
  logic                  accept;
  result_t               head;
  fifo_status_t          fifo_status;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      allowed_count <= '0;
      for (int i = 0; i < ALLOWED_ENTRIES; i++) allowed_entry[i] <= '0;
    end else if (cfg_valid) begin
      if (cfg_index == CFG_ALLOWED_COUNT) begin
        allowed_count <= cfg_data[2:0];
      end else if (cfg_index >= CFG_ENTRY_FIRST && cfg_index <= CFG_ENTRY_LAST) begin
        allowed_entry[cfg_index - CFG_ENTRY_FIRST] <= cfg_data;
      end
    end
  end

  assign host       = s_tdata[15:0] & HOST_MASK;
  assign table_size = (allowed_count > 3'(ALLOWED_ENTRIES)) ? 3'(ALLOWED_ENTRIES)
                                                            : allowed_count;

  // Parallel match over the table; the lowest matching entry wins.
  always_comb begin
    lookup_hit = 1'b0;
    lookup_max = '0;
    for (int i = ALLOWED_ENTRIES - 1; i >= 0; i--) begin
      if (3'(i) < table_size && allowed_entry[i][15:0] == host) begin
        lookup_hit = 1'b1;
        lookup_max = allowed_entry[i][23:16];
      end
    end
  end

  always_comb begin
    run_value_next      = run_value;
    run_length_next     = run_length;
    run_host_label_next = run_host_label;
    run_max_order_next  = run_max_order;
    run_open_next       = run_open;
    error_seen_next     = error_seen;
    runs_emitted_next   = runs_emitted;
    res0 = '0;
    res1 = '0;
    nres = 2'd0;

    if (!error_seen) begin
      if (run_open && s_tdata == run_value) begin
        if (run_length == COUNT_MAX) error_seen_next = 1'b1;
        else run_length_next = run_length + 8'd1;
      end else begin
        if (run_open) begin
          run_open_next = 1'b0;
          if (run_length > run_max_order) begin
            error_seen_next = 1'b1;
          end else begin
            if (runs_emitted != COUNT_MAX) runs_emitted_next = runs_emitted + 8'd1;
            res0 = '{host_label: run_host_label, run_order: run_length,
                     run_total: runs_emitted_next, tuple_end: 1'b0, tuple_error: 1'b0};
            nres = 2'd1;
          end
        end
        if (!error_seen_next) begin
          if (lookup_hit) begin
            run_value_next      = s_tdata;
            run_length_next     = 8'd1;
            run_host_label_next = host;
            run_max_order_next  = lookup_max;
            run_open_next       = 1'b1;
          end else begin
            error_seen_next = 1'b1;
          end
        end
      end
    end

    if (s_tlast) begin
      // The run still open at the end of the tuple closes with the end mark.
      if (!error_seen_next && run_open_next) begin
        if (run_length_next > run_max_order_next) begin
          error_seen_next = 1'b1;
        end else begin
          if (runs_emitted_next != COUNT_MAX) runs_emitted_next = runs_emitted_next + 8'd1;
          if (nres == 2'd0) begin
            res0 = '{host_label: run_host_label_next, run_order: run_length_next,
                     run_total: runs_emitted_next, tuple_end: 1'b1, tuple_error: 1'b0};
          end else begin
            res1 = '{host_label: run_host_label_next, run_order: run_length_next,
                     run_total: runs_emitted_next, tuple_end: 1'b1, tuple_error: 1'b0};
          end
          nres = nres + 2'd1;
        end
      end
      if (error_seen_next) begin
        if (nres == 2'd0) begin
          res0 = '{host_label: 16'd0, run_order: 8'd0, run_total: runs_emitted_next,
                   tuple_end: 1'b1, tuple_error: 1'b1};
        end else begin
          res1 = '{host_label: 16'd0, run_order: 8'd0, run_total: runs_emitted_next,
                   tuple_end: 1'b1, tuple_error: 1'b1};
        end
        nres = nres + 2'd1;
      end
      run_value_next      = '0;
      run_length_next     = '0;
      run_host_label_next = '0;
      run_max_order_next  = '0;
      run_open_next       = 1'b0;
      error_seen_next     = 1'b0;
      runs_emitted_next   = '0;
    end
  end

  assign s_tready = fifo_status.room_two;
  assign accept   = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      run_value      <= '0;
      run_length     <= '0;
      run_host_label <= '0;
      run_max_order  <= '0;
      run_open       <= 1'b0;
      error_seen     <= 1'b0;
      runs_emitted   <= '0;
    end else if (accept) begin
      run_value      <= run_value_next;
      run_length     <= run_length_next;
      run_host_label <= run_host_label_next;
      run_max_order  <= run_max_order_next;
      run_open       <= run_open_next;
      error_seen     <= error_seen_next;
      runs_emitted   <= runs_emitted_next;
    end
  end

  trlv_result_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_count (accept ? nres : 2'd0),
    .push_data0 (res0),
    .push_data1 (res1),
    .pop        (m_tready && fifo_status.not_empty),
    .head       (head),
    .status     (fifo_status)
  );

  assign m_tvalid = fifo_status.not_empty;
  assign m_tdata  = {head.run_total, head.run_order, head.host_label};
  assign m_tlast  = head.tuple_end;
  assign m_tuser  = head.tuple_error;

endmodule

`default_nettype wire

/* design/trlv_checker.sv */
// Port-level checks for the tuple run-length validator, bound to its top level.
// Watches only the clock, the reset and the output item group.
`default_nettype none

module trlv_checker (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic [31:0]                       m_tdata,
  input  wire logic                              m_tuser,
  input  wire logic                              m_tlast,
  input  wire logic                              m_tvalid,
  input  wire logic                              m_tready
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("output item dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser))
    else $error("output item changed while stalled");

  // An error result always closes its tuple.
  a_err_ends: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tlast)
    else $error("error item without tuple end");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata[23:0] == 24'd0)
    else $error("error item carries a label or order");

  // A good run has at least one element and counts itself in the run total.
  a_good_nonzero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata[23:16] != 8'd0 && m_tdata[31:24] != 8'd0)
    else $error("good item with zero order or zero run total");

endmodule

bind tuple_run_length_validator_unit trlv_checker u_trlv_checker (.*);

`default_nettype wire
